// ===== rtl/core/bpa_pkg.sv =====
// Shared types and constants of the buffer pool allocator.
// Holds the status, operation and register codes and the token that walks the cell row.
// No dependencies.
package bpa_pkg;

  localparam int ADDR_W  = 32;
  localparam int SIZE_W  = 16;
  localparam int BCNT_W  = 6;
  localparam int IDX_W   = 5;
  // Wide enough for the saturated buffer count and any cell index.
  localparam int CNT_W   = 8;
  localparam int CFGI_W  = 2;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NONE_FREE    = 2'd1,
    ST_ALREADY_FREE = 2'd2,
    ST_UNKNOWN      = 2'd3
  } status_e;

  typedef enum logic {
    FUNC_ALLOC   = 1'b0,
    FUNC_RELEASE = 1'b1
  } func_e;

  typedef enum logic [CFGI_W-1:0] {
    REG_BUFFER_COUNT = 2'd0,
    REG_BUFFER_SIZE  = 2'd1,
    REG_BASE_ADDRESS = 2'd2,
    REG_UNUSED       = 2'd3
  } cfg_reg_e;

  // One request travelling down the row; the result rides along with it.
  typedef struct packed {
    logic              valid;
    func_e             func;
    logic [ADDR_W-1:0] target;
    logic [ADDR_W-1:0] cur_addr;
    logic              done;
    status_e           status;
    logic [ADDR_W-1:0] addr;
    logic [IDX_W-1:0]  index;
  } token_t;

endpackage

// ===== rtl/core/bpa_cell.sv =====
// One cell of the allocator row: the free bit of one buffer and a token stage.
// Depends on bpa_pkg.
module bpa_cell #(
  parameter int IDX = 0
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        advance,
  input  logic [bpa_pkg::CNT_W-1:0]   active_count,
  input  logic [bpa_pkg::SIZE_W-1:0]  buffer_size,
  input  bpa_pkg::token_t             tok_in,
  output bpa_pkg::token_t             tok_out,
  output logic                        free
);

  bpa_pkg::token_t tok_next;
  logic            free_next;
  logic            active;

  assign active = (bpa_pkg::CNT_W'(IDX) < active_count);

  always_comb begin
    tok_next          = tok_in;
    tok_next.cur_addr = tok_in.cur_addr + bpa_pkg::ADDR_W'(buffer_size);
    free_next         = free;
    if (tok_in.valid && !tok_in.done && active) begin
      unique case (tok_in.func)
        bpa_pkg::FUNC_ALLOC: begin
          if (free) begin
            free_next      = 1'b0;
            tok_next.done  = 1'b1;
            tok_next.status = bpa_pkg::ST_OK;
            tok_next.addr  = tok_in.cur_addr;
            tok_next.index = bpa_pkg::IDX_W'(IDX);
          end
        end
        bpa_pkg::FUNC_RELEASE: begin
          if (tok_in.cur_addr == tok_in.target) begin
            tok_next.done  = 1'b1;
            tok_next.addr  = tok_in.target;
            tok_next.index = bpa_pkg::IDX_W'(IDX);
            if (free) begin
              tok_next.status = bpa_pkg::ST_ALREADY_FREE;
            end else begin
              free_next       = 1'b1;
              tok_next.status = bpa_pkg::ST_OK;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free          <= 1'b1;
      tok_out.valid <= 1'b0;
    end else if (advance) begin
      free    <= free_next;
      tok_out <= tok_next;
    end
  end

endmodule

// ===== rtl/core/buffer_pool_allocator_core.sv =====
// Buffer pool allocator: first-fit allocation and release of equal-sized buffers.
// Usage:
//   Requests arrive on the s_axis channel: s_axis_tuser is the operation
//   (0 allocate, 1 release), s_axis_tdata the address to release. Every request
//   gives exactly one response beat on m_axis: m_axis_tuser carries the status
//   (0 ok, 1 none free, 2 already free, 3 unknown buffer), m_axis_tdata the
//   buffer address and index.
//   The cfg channel writes buffer_count (0), buffer_size (1), base_address (2);
//   write only while no request is in flight. cfg_ready is always high.
// Timing:
//   A request walks a row of NUM_BUFFERS cells, one cell per cycle unless the
//   row is frozen; each cell owns one free bit and steps the running address by
//   buffer_size. The response enters the output register as the token leaves the
//   last cell, and one request is in the row at a time, so a new request is
//   taken only after the last one has left the row. A response waiting in the output
//   register does not block the next request; the row only freezes when its token
//   reaches the end while the output register is still held by a stalled receiver.
// Reset: synchronous; every buffer becomes free, registers return to
//   count 32, size 1536, base 0.
module buffer_pool_allocator_core #(
  parameter int NUM_BUFFERS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] release_address
  input  logic        s_axis_tuser,   // [0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] buffer_address, [36:32] buffer_index, zero pad
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [bpa_pkg::BCNT_W-1:0] buffer_count;
  logic [bpa_pkg::SIZE_W-1:0] buffer_size;
  logic [bpa_pkg::ADDR_W-1:0] base_address;
  logic [bpa_pkg::CNT_W-1:0]  active_count;

  bpa_pkg::token_t            chain [NUM_BUFFERS+1];
  bpa_pkg::token_t            inject;
  bpa_pkg::token_t            last_tok;
  logic [NUM_BUFFERS-1:0]     free_map;
  logic [NUM_BUFFERS-1:0]     tok_valid;

  logic                       busy;
  logic                       s_accept;
  logic                       advance;
  logic                       out_take;
  bpa_pkg::status_e           out_status;
  logic [bpa_pkg::ADDR_W-1:0] out_addr;
  logic [bpa_pkg::IDX_W-1:0]  out_index;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_count <= bpa_pkg::BCNT_W'(32);
      buffer_size  <= bpa_pkg::SIZE_W'(1536);
      base_address <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (bpa_pkg::cfg_reg_e'(cfg_index))
        bpa_pkg::REG_BUFFER_COUNT: buffer_count <= cfg_data[bpa_pkg::BCNT_W-1:0];
        bpa_pkg::REG_BUFFER_SIZE:  buffer_size  <= cfg_data[bpa_pkg::SIZE_W-1:0];
        bpa_pkg::REG_BASE_ADDRESS: base_address <= cfg_data;
        default: ;
      endcase
    end
  end

  // Saturate the count at the number of cells
  always_comb begin
    if (bpa_pkg::CNT_W'(buffer_count) > bpa_pkg::CNT_W'(NUM_BUFFERS)) begin
      active_count = bpa_pkg::CNT_W'(NUM_BUFFERS);
    end else begin
      active_count = bpa_pkg::CNT_W'(buffer_count);
    end
  end

  // Request injection
  assign s_axis_tready = !busy;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_comb begin
    inject.valid    = s_accept;
    inject.func     = bpa_pkg::func_e'(s_axis_tuser);
    inject.target   = s_axis_tdata;
    inject.cur_addr = base_address;
    inject.done     = 1'b0;
    inject.status   = (s_axis_tuser == bpa_pkg::FUNC_RELEASE) ? bpa_pkg::ST_UNKNOWN
                                                              : bpa_pkg::ST_NONE_FREE;
    inject.addr     = '0;
    inject.index    = '0;
  end

  assign chain[0] = inject;
  assign last_tok = chain[NUM_BUFFERS];

  // Freeze the row while the finished token cannot leave
  assign out_take = last_tok.valid && (!m_axis_tvalid || m_axis_tready);
  assign advance  = !last_tok.valid || out_take;

  for (genvar i = 0; i < NUM_BUFFERS; i++) begin : g_cell
    bpa_cell #(
      .IDX(i)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .advance     (advance),
      .active_count(active_count),
      .buffer_size (buffer_size),
      .tok_in      (chain[i]),
      .tok_out     (chain[i+1]),
      .free        (free_map[i])
    );
    assign tok_valid[i] = chain[i+1].valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (s_accept) begin
      busy <= 1'b1;
    end else if (out_take) begin
      busy <= 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_take) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      out_status <= last_tok.status;
      out_addr   <= last_tok.addr;
      out_index  <= last_tok.index;
    end
  end

  assign m_axis_tuser = out_status;
  assign m_axis_tdata = {3'b000, out_index, out_addr};

  // At most one request is ever in the row
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tok_valid))
    else $error("more than one token in the cell row");

  // A token in the row implies the block is busy
  a_busy_cover: assert property (@(posedge clk) disable iff (rst)
    (tok_valid != '0) |-> busy)
    else $error("token in row while idle");

  // A request flips at most one free bit per cycle
  a_one_flip: assert property (@(posedge clk) disable iff (rst)
    $countones(free_map ^ $past(free_map)) <= 1)
    else $error("several free bits changed in one cycle");

  // The free map only changes while a request is in flight or entering cell 0
  a_map_idle: assert property (@(posedge clk) disable iff (rst)
    (!busy && !s_accept) |=> $stable(free_map))
    else $error("free map changed while idle");

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for buffer_pool_allocator_core: first-fit allocate and release
// against a behavioral pool model, under random idling, long receiver stalls and
// several register settings. Depends on bpa_pkg and the core RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NB        = 32;
  localparam int QUIET_MAX = 2000;   // cycles with no beat on any channel
  localparam int RX_HOLD   = 400;

  typedef struct packed {
    bpa_pkg::func_e func;
    logic [31:0]    addr;
  } pool_req_t;

  typedef struct packed {
    bpa_pkg::status_e status;
    logic [31:0]      addr;
    logic [4:0]       index;
  } pool_reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  pool_req_t   pend_reqs[$];
  pool_reply_t replies_due[$];

  // Shadow of the pool: free bits and register contents
  logic [NB-1:0] pool_free = '1;
  logic [5:0]    cnt_cfg   = 6'd32;
  logic [15:0]   size_cfg  = 16'd1536;
  logic [31:0]   base_cfg  = '0;

  logic req_taken   = 1'b0;
  logic stall_rx    = 1'b0;
  int   snd_idle_pct = 0;
  int   rcv_idle_pct = 0;
  int   mismatches   = 0;
  int   quiet_cycles = 0;

  buffer_pool_allocator_core #(.NUM_BUFFERS(NB)) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int active_slots();
    return (cnt_cfg > NB) ? NB : int'(cnt_cfg);
  endfunction

  function automatic logic [31:0] slot_addr(int i);
    return base_cfg + 32'(i) * {16'd0, size_cfg};
  endfunction

  task automatic apply_reg(logic [1:0] idx, logic [31:0] val);
    case (bpa_pkg::cfg_reg_e'(idx))
      bpa_pkg::REG_BUFFER_COUNT: cnt_cfg = val[5:0];
      bpa_pkg::REG_BUFFER_SIZE:  size_cfg = val[15:0];
      bpa_pkg::REG_BASE_ADDRESS: base_cfg = val;
      default: ;
    endcase
  endtask

  // Work out the reply to one accepted request and update the free bits.
  task automatic pool_answer(bpa_pkg::func_e op, logic [31:0] target);
    pool_reply_t r;
    int          n;
    logic        hit;
    n = active_slots();
    hit = 1'b0;
    r.addr = '0;
    r.index = '0;
    if (op == bpa_pkg::FUNC_ALLOC) begin
      r.status = bpa_pkg::ST_NONE_FREE;
      for (int i = 0; i < n && !hit; i++) begin
        if (pool_free[i]) begin
          pool_free[i] = 1'b0;
          r.status = bpa_pkg::ST_OK;
          r.addr = slot_addr(i);
          r.index = 5'(i);
          hit = 1'b1;
        end
      end
    end else begin
      r.status = bpa_pkg::ST_UNKNOWN;
      for (int i = 0; i < n && !hit; i++) begin
        if (slot_addr(i) == target) begin
          r.status = pool_free[i] ? bpa_pkg::ST_ALREADY_FREE : bpa_pkg::ST_OK;
          pool_free[i] = 1'b1;
          r.addr = target;
          r.index = 5'(i);
          hit = 1'b1;
        end
      end
    end
    replies_due.push_back(r);
  endtask

  task automatic match_reply();
    pool_reply_t      want;
    bpa_pkg::status_e got_st;
    logic [31:0]      got_addr;
    logic [4:0]       got_idx;
    got_st = bpa_pkg::status_e'(m_axis_tuser);
    got_addr = m_axis_tdata[31:0];
    got_idx = m_axis_tdata[36:32];
    if (replies_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] unexpected beat: status %0d addr %h index %0d", $realtime,
                 got_st, got_addr, got_idx);
    end else begin
      want = replies_due.pop_front();
      if (got_st !== want.status || got_addr !== want.addr || got_idx !== want.index) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] reply differs: status %0d/%0d addr %h/%h index %0d/%0d (exp/got)",
                   $realtime, want.status, got_st, want.addr, got_addr, want.index, got_idx);
      end
    end
  endtask

  // Scoreboard and watchdog; everything sampled at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      req_taken <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      req_taken <= s_axis_tvalid && s_axis_tready;
      if (cfg_valid && cfg_ready)
        apply_reg(cfg_index, cfg_data);
      if (s_axis_tvalid && s_axis_tready)
        pool_answer(bpa_pkg::func_e'(s_axis_tuser), s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready)
        match_reply();
      if ((cfg_valid && cfg_ready) || (s_axis_tvalid && s_axis_tready) ||
          (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_MAX) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Request driver: drop the accepted beat, hold an offered one, else offer or idle
  always @(negedge clk) begin
    if (!rst) begin
      if (req_taken)
        pend_reqs.delete(0);
      if (s_axis_tvalid && !req_taken) begin
        s_axis_tvalid <= 1'b1;
      end else if (pend_reqs.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= pend_reqs[0].func;
        s_axis_tdata <= pend_reqs[0].addr;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst)
      m_axis_tready <= !stall_rx && ($urandom_range(99) >= rcv_idle_pct);
  end

  task automatic queue_req(bpa_pkg::func_e f, logic [31:0] a);
    pool_req_t rq;
    rq.func = f;
    rq.addr = a;
    pend_reqs.push_back(rq);
  endtask

  // Allocs and releases; releases mostly live, some past the count, off by one, or noise
  task automatic queue_random(int count);
    pool_req_t rq;
    int        alloc_pct;
    int        n;
    int        k;
    alloc_pct = 50;
    n = active_slots();
    for (int j = 0; j < count; j++) begin
      if (j % 40 == 0)
        alloc_pct = 25 + 25 * int'($urandom_range(2));
      rq.func = bpa_pkg::FUNC_RELEASE;
      rq.addr = $urandom;
      if ($urandom_range(99) < alloc_pct) begin
        rq.func = bpa_pkg::FUNC_ALLOC;
      end else begin
        k = $urandom_range(99);
        if (n > 0 && k < 80)
          rq.addr = slot_addr($urandom_range(n - 1));
        else if (k < 88)
          rq.addr = slot_addr($urandom_range(NB + 7));
        else if (k < 94)
          rq.addr = slot_addr($urandom_range(NB - 1)) + ($urandom_range(1) ? 32'd1 : -32'd1);
      end
      pend_reqs.push_back(rq);
    end
  endtask

  task automatic write_reg(bpa_pkg::cfg_reg_e r, logic [31:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait for every request to be answered, then let the row empty out
  task automatic drain();
    while (pend_reqs.size() != 0 || replies_due.size() != 0)
      @(negedge clk);
    repeat (NB + 4) @(posedge clk);
  endtask

  task automatic set_pool(logic [5:0] cnt, logic [15:0] sz, logic [31:0] base);
    write_reg(bpa_pkg::REG_BUFFER_COUNT, {26'd0, cnt});
    write_reg(bpa_pkg::REG_BUFFER_SIZE, {16'd0, sz});
    write_reg(bpa_pkg::REG_BASE_ADDRESS, base);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    snd_idle_pct = 30;
    rcv_idle_pct = 80;
    // Reset settings: double release, stray addresses, address past the count
    queue_req(bpa_pkg::FUNC_ALLOC, 32'h0);
    queue_req(bpa_pkg::FUNC_ALLOC, 32'hFFFF_FFFF);
    queue_req(bpa_pkg::FUNC_RELEASE, 32'd1536);
    queue_req(bpa_pkg::FUNC_RELEASE, 32'd1536);
    queue_req(bpa_pkg::FUNC_RELEASE, 32'hFFFF_FFFF);
    queue_req(bpa_pkg::FUNC_RELEASE, 32'd1537);
    queue_req(bpa_pkg::FUNC_RELEASE, 32'd32 * 32'd1536);
    queue_req(bpa_pkg::FUNC_RELEASE, 32'd31 * 32'd1536);
    drain();
    // Three buffers, largest size, addresses wrap past the top
    set_pool(6'd3, 16'hFFFF, 32'hFFFF_0000);
    queue_req(bpa_pkg::FUNC_ALLOC, 32'h0);
    queue_req(bpa_pkg::FUNC_ALLOC, 32'h0);
    queue_req(bpa_pkg::FUNC_ALLOC, 32'h0);
    queue_req(bpa_pkg::FUNC_RELEASE, 32'hFFFF_FFFF);
    queue_req(bpa_pkg::FUNC_RELEASE, 32'h0000_FFFE);
    queue_req(bpa_pkg::FUNC_RELEASE, 32'hFFFF_0000);
    drain();
    // No active buffer at all
    write_reg(bpa_pkg::REG_BUFFER_COUNT, 32'd0);
    queue_req(bpa_pkg::FUNC_ALLOC, 32'h0);
    queue_req(bpa_pkg::FUNC_RELEASE, 32'hFFFF_0000);
    drain();
    // Zero size: every buffer sits at the base, buffer 0 always matches
    set_pool(6'd32, 16'd0, 32'h8000_0000);
    queue_req(bpa_pkg::FUNC_ALLOC, 32'h0);
    queue_req(bpa_pkg::FUNC_RELEASE, 32'h8000_0000);
    queue_req(bpa_pkg::FUNC_RELEASE, 32'h8000_0000);
    drain();

    set_pool(6'd32, 16'd1536, 32'h0);
    queue_random(300);
    drain();
    // Count above the row length saturates
    set_pool(6'd63, 16'd100, 32'hFFFF_FC00);
    queue_random(250);
    drain();

    snd_idle_pct = 80;
    rcv_idle_pct = 30;
    set_pool(6'd1, 16'hFFFF, $urandom);
    queue_random(150);
    drain();
    set_pool(6'd5, 16'd1, 32'hFFFF_FFFE);
    queue_random(200);
    drain();

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    set_pool(6'd17, 16'($urandom_range(1, 65535)), $urandom);
    queue_random(300);
    fork
      begin
        repeat (30) @(posedge clk);
        stall_rx = 1'b1;
        repeat (RX_HOLD) @(posedge clk);
        stall_rx = 1'b0;
      end
    join_none
    drain();
    set_pool(6'd32, 16'hFFFF, 32'hFFFF_FFFF);
    queue_random(300);
    drain();
    write_reg(bpa_pkg::REG_BUFFER_COUNT, 32'd0);
    queue_random(40);
    drain();
    set_pool(6'd40, 16'd0, $urandom);
    queue_random(100);
    drain();
    // Unused register index must leave the pool settings alone
    set_pool(6'd32, 16'd1536, 32'h0);
    write_reg(bpa_pkg::REG_UNUSED, $urandom);
    queue_random(60);
    drain();

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
